// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by the controller, the slot datapath, the top level and the checker.
package spq_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 6;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    do_enq;
    logic    do_deq;
    logic    load_out;
    status_e status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Controller for the sorted priority queue: input capture, op issue, result valid.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.status  = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the op until the result register can take it
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
          if (stat_i.cmd == CMD_ENQ) begin
            if (stat_i.full) cmd_o.status = ST_FULL;
            else             cmd_o.do_enq = 1'b1;
          end else begin
            if (stat_i.empty) cmd_o.status = ST_EMPTY;
            else              cmd_o.do_deq = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/spq_datapath.sv =====
// Slot array of the sorted priority queue: input register, sorted slots with
// valid bits, count and result register. Depends on spq_pkg.
module spq_datapath import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_cmd_i,
  input  logic [IdW-1:0]   in_id_i,
  input  logic [PrioW-1:0] in_prio_i,
  input  dp_cmd_t          cmd_i,
  output dp_stat_t         stat_o,
  output logic [1:0]       out_status_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [PrioW-1:0] out_prio_o,
  output logic [OccW-1:0]  out_occ_o,
  output logic             out_full_o,
  output logic             out_empty_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  cmd_e             in_cmd_q;
  logic [IdW-1:0]   in_id_q;
  logic [PrioW-1:0] in_prio_q;

  logic [IdW-1:0]   slot_id_q   [CAPACITY];
  logic [IdW-1:0]   slot_id_d   [CAPACITY];
  logic [PrioW-1:0] slot_prio_q [CAPACITY];
  logic [PrioW-1:0] slot_prio_d [CAPACITY];
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CAPACITY-1:0] le;
  logic [CntW-1:0]  count_q, count_d;

  logic [1:0]       res_status_q;
  logic [IdW-1:0]   res_id_q;
  logic [PrioW-1:0] res_prio_q;
  logic [OccW-1:0]  res_occ_q;
  logic             res_full_q, res_empty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_cmd_q  <= cmd_e'(in_cmd_i);
      in_id_q   <= in_id_i;
      in_prio_q <= in_prio_i;
    end
  end

  assign stat_o.cmd   = in_cmd_q;
  assign stat_o.full  = (count_q == CntW'(CAPACITY));
  assign stat_o.empty = (count_q == '0);

  // Each slot compares against the new priority; sorted order makes le a prefix.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign le[i] = valid_q[i] && (slot_prio_q[i] <= in_prio_q);

    if (i == CAPACITY - 1) begin : g_last
      always_comb begin
        slot_id_d[i]   = slot_id_q[i];
        slot_prio_d[i] = slot_prio_q[i];
        if (cmd_i.do_enq && !le[i]) begin
          if (le[i-1]) begin
            slot_id_d[i]   = in_id_q;
            slot_prio_d[i] = in_prio_q;
          end else begin
            slot_id_d[i]   = slot_id_q[i-1];
            slot_prio_d[i] = slot_prio_q[i-1];
          end
        end
      end
      assign valid_d[i] = cmd_i.do_enq ? (valid_q[i] | valid_q[i-1])
                        : cmd_i.do_deq ? 1'b0 : valid_q[i];
    end else if (i == 0) begin : g_first
      always_comb begin
        slot_id_d[i]   = slot_id_q[i];
        slot_prio_d[i] = slot_prio_q[i];
        if (cmd_i.do_enq && !le[i]) begin
          slot_id_d[i]   = in_id_q;
          slot_prio_d[i] = in_prio_q;
        end else if (cmd_i.do_deq) begin
          slot_id_d[i]   = slot_id_q[i+1];
          slot_prio_d[i] = slot_prio_q[i+1];
        end
      end
      assign valid_d[i] = cmd_i.do_enq ? 1'b1
                        : cmd_i.do_deq ? valid_q[i+1] : valid_q[i];
    end else begin : g_mid
      always_comb begin
        slot_id_d[i]   = slot_id_q[i];
        slot_prio_d[i] = slot_prio_q[i];
        if (cmd_i.do_enq && !le[i]) begin
          if (le[i-1]) begin
            slot_id_d[i]   = in_id_q;
            slot_prio_d[i] = in_prio_q;
          end else begin
            slot_id_d[i]   = slot_id_q[i-1];
            slot_prio_d[i] = slot_prio_q[i-1];
          end
        end else if (cmd_i.do_deq) begin
          slot_id_d[i]   = slot_id_q[i+1];
          slot_prio_d[i] = slot_prio_q[i+1];
        end
      end
      assign valid_d[i] = cmd_i.do_enq ? (valid_q[i] | valid_q[i-1])
                        : cmd_i.do_deq ? valid_q[i+1] : valid_q[i];
    end

    always_ff @(posedge clk_i) begin
      slot_id_q[i]   <= slot_id_d[i];
      slot_prio_q[i] <= slot_prio_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_enq)      count_d = count_q + CntW'(1);
    else if (cmd_i.do_deq) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_status_q <= cmd_i.status;
      res_id_q     <= cmd_i.do_deq ? slot_id_q[0] : '0;
      res_prio_q   <= cmd_i.do_deq ? slot_prio_q[0] : '0;
      res_occ_q    <= OccW'(count_d);
      res_full_q   <= (count_d == CntW'(CAPACITY));
      res_empty_q  <= (count_d == '0);
    end
  end

  assign out_status_o = res_status_q;
  assign out_id_o     = res_id_q;
  assign out_prio_o   = res_prio_q;
  assign out_occ_o    = res_occ_q;
  assign out_full_o   = res_full_q;
  assign out_empty_o  = res_empty_q;

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// Channel   Dir  Bits in tdata / tuser
// s_axis    in   tuser: command; tdata: entry_id[15:0], entry_priority[23:16]
// m_axis    out  tdata: status[1:0], out_id[17:2], out_priority[25:18],
//                       occupancy[31:26], is_full[32], is_empty[33]
//
// One item at a time: it is first captured, then every slot compares and shifts
// at once. The result register holds one item; the op waits while that item
// is unread, and s_axis_tready is low meanwhile.
// Reset clears the valid bits and the count; slot payload needs no reset.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // entry_id, entry_priority
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status, out_id, out_priority, occupancy,
                                     // is_full, is_empty, zero pad
);

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [1:0]       res_status;
  logic [IdW-1:0]   res_id;
  logic [PrioW-1:0] res_prio;
  logic [OccW-1:0]  res_occ;
  logic             res_full, res_empty;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser),
    .in_id_i      (s_axis_tdata[15:0]),
    .in_prio_i    (s_axis_tdata[23:16]),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .out_status_o (res_status),
    .out_id_o     (res_id),
    .out_prio_o   (res_prio),
    .out_occ_o    (res_occ),
    .out_full_o   (res_full),
    .out_empty_o  (res_empty)
  );

  assign m_axis_tdata = {6'd0, res_empty, res_full, res_occ, res_prio, res_id, res_status};

endmodule

// ===== src/spq_checker.sv =====
// Port-level checks for sorted_priority_queue_core, bound to the top level.
// Depends on spq_pkg.
module spq_checker import spq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33] == (m_axis_tdata[31:26] == '0))
    else $error("is_empty disagrees with occupancy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |-> m_axis_tdata[32]
      && m_axis_tdata[25:2] == '0)
    else $error("full status without full flag or with data");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_EMPTY |-> m_axis_tdata[33]
      && m_axis_tdata[25:2] == '0)
    else $error("empty status without empty flag or with data");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
